### rtl/json_string_unescape_utf8_top_assert.svh
// Assertion macros used by the RTL of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_ASSERT_SVH

// checked only out of reset
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/jsu_pkg.sv
// Package for the JSON string unescaper: phases, result kinds and result packet.
package jsu_pkg;

  localparam int unsigned LenW = 16;
  localparam int unsigned MaxRes = 4;

  typedef enum logic [3:0] {
    PH_WAIT     = 4'd0,
    PH_STR      = 4'd1,
    PH_ESC      = 4'd2,
    PH_HEX0     = 4'd3,
    PH_HEX1     = 4'd4,
    PH_HEX2     = 4'd5,
    PH_HEX3     = 4'd6,
    PH_LOW_BS   = 4'd7,
    PH_LOW_U    = 4'd8,
    PH_LOW_HEX0 = 4'd9,
    PH_LOW_HEX1 = 4'd10,
    PH_LOW_HEX2 = 4'd11,
    PH_LOW_HEX3 = 4'd12
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // all results caused by one input item
  typedef struct packed {
    logic [2:0]              num;
    kind_e                   kind;
    logic [MaxRes-1:0][7:0]  bytes;
    logic [LenW-1:0]         len;
  } pkt_t;

endpackage

### rtl/json_string_unescape_utf8_top.sv
// Top level of the JSON string literal unescaper with UTF-8 output.
// One byte of JSON text per input item, starting at the opening quote. An input
// byte is taken every cycle while the result register can drain. A \u escape
// ends in 1 to 3 result items and a surrogate pair in 4; the single result
// register sends one per cycle while m_axis_tready is high, so the input stalls
// behind such a byte until its last result is taken. A done item carries the
// saturating decoded length; an error item returns the parser to waiting for an
// opening quote. tlast marks the final result of each input byte.
module json_string_unescape_utf8_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_byte[7:0], decoded_length[23:8]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);

  jsu_pkg::pkt_t pkt;
  logic          take;

  assign take = s_axis_tvalid && s_axis_tready;

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_byte_i (s_axis_tdata),
    .pkt_o     (pkt)
  );

  jsu_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .pkt_i         (pkt),
    .ready_o       (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### rtl/jsu_decode.sv
// Parser state and per-byte decode of escapes, \u escapes and surrogate pairs.
module jsu_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    in_byte_i,
  output jsu_pkg::pkt_t pkt_o
);

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNul = 8'h00;

  jsu_pkg::phase_e          phase_q, phase_d;
  logic [15:0]              cu_q, cu_d;
  logic [9:0]               hb_q, hb_d;
  logic [jsu_pkg::LenW-1:0] cnt_q, cnt_d;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  always_comb begin
    logic [4:0]               hx;
    logic [15:0]              cu_n;
    logic [20:0]              cp;
    logic [jsu_pkg::LenW:0]   sum;
    hx = hex_value(in_byte_i);
    cu_n = {cu_q[11:0], hx[3:0]};
    cp = {1'b0, hb_q, cu_n[9:0]} + 21'h10000;
    phase_d = phase_q;
    cu_d = cu_q;
    hb_d = hb_q;
    pkt_o = '0;
    pkt_o.kind = jsu_pkg::KIND_DATA;
    case (phase_q)
      jsu_pkg::PH_WAIT: begin
        if (in_byte_i == ChQuote) begin
          phase_d = jsu_pkg::PH_STR;
          cu_d = '0;
        end else begin
          pkt_o.num = 3'd1;
          pkt_o.kind = jsu_pkg::KIND_ERR;
        end
      end
      jsu_pkg::PH_STR: begin
        if (in_byte_i == ChNul) begin
          phase_d = jsu_pkg::PH_WAIT;
          pkt_o.num = 3'd1;
          pkt_o.kind = jsu_pkg::KIND_ERR;
        end else if (in_byte_i == ChQuote) begin
          phase_d = jsu_pkg::PH_WAIT;
          pkt_o.num = 3'd1;
          pkt_o.kind = jsu_pkg::KIND_DONE;
          pkt_o.len = cnt_q;
        end else if (in_byte_i == ChBslash) begin
          phase_d = jsu_pkg::PH_ESC;
        end else begin
          pkt_o.num = 3'd1;
          pkt_o.bytes[0] = in_byte_i;
        end
      end
      jsu_pkg::PH_ESC: begin
        phase_d = jsu_pkg::PH_STR;
        pkt_o.num = 3'd1;
        case (in_byte_i)
          ChQuote:  pkt_o.bytes[0] = ChQuote;
          ChBslash: pkt_o.bytes[0] = ChBslash;
          8'h62:    pkt_o.bytes[0] = 8'h08;
          8'h66:    pkt_o.bytes[0] = 8'h0C;
          8'h6E:    pkt_o.bytes[0] = 8'h0A;
          8'h72:    pkt_o.bytes[0] = 8'h0D;
          8'h74:    pkt_o.bytes[0] = 8'h09;
          8'h75: begin
            phase_d = jsu_pkg::PH_HEX0;
            cu_d = '0;
            pkt_o.num = 3'd0;
          end
          default: begin
            phase_d = jsu_pkg::PH_WAIT;
            pkt_o.kind = jsu_pkg::KIND_ERR;
          end
        endcase
      end
      jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2,
      jsu_pkg::PH_LOW_HEX0, jsu_pkg::PH_LOW_HEX1, jsu_pkg::PH_LOW_HEX2: begin
        if (!hx[4]) begin
          phase_d = jsu_pkg::PH_WAIT;
          pkt_o.num = 3'd1;
          pkt_o.kind = jsu_pkg::KIND_ERR;
        end else begin
          cu_d = cu_n;
          phase_d = jsu_pkg::phase_e'(phase_q + 4'd1);
        end
      end
      jsu_pkg::PH_HEX3: begin
        if (!hx[4]) begin
          phase_d = jsu_pkg::PH_WAIT;
          pkt_o.num = 3'd1;
          pkt_o.kind = jsu_pkg::KIND_ERR;
        end else begin
          cu_d = cu_n;
          if (cu_n[15:10] == 6'b110110) begin
            hb_d = cu_n[9:0];
            phase_d = jsu_pkg::PH_LOW_BS;
          end else begin
            phase_d = jsu_pkg::PH_STR;
            if (cu_n[15:7] == 9'd0) begin
              pkt_o.num = 3'd1;
              pkt_o.bytes[0] = {1'b0, cu_n[6:0]};
            end else if (cu_n[15:11] == 5'd0) begin
              pkt_o.num = 3'd2;
              pkt_o.bytes[0] = {3'b110, cu_n[10:6]};
              pkt_o.bytes[1] = {2'b10, cu_n[5:0]};
            end else begin
              pkt_o.num = 3'd3;
              pkt_o.bytes[0] = {4'b1110, cu_n[15:12]};
              pkt_o.bytes[1] = {2'b10, cu_n[11:6]};
              pkt_o.bytes[2] = {2'b10, cu_n[5:0]};
            end
          end
        end
      end
      jsu_pkg::PH_LOW_BS: begin
        if (in_byte_i == ChBslash) begin
          phase_d = jsu_pkg::PH_LOW_U;
        end else begin
          phase_d = jsu_pkg::PH_WAIT;
          pkt_o.num = 3'd1;
          pkt_o.kind = jsu_pkg::KIND_ERR;
        end
      end
      jsu_pkg::PH_LOW_U: begin
        if (in_byte_i == 8'h75) begin
          phase_d = jsu_pkg::PH_LOW_HEX0;
          cu_d = '0;
        end else begin
          phase_d = jsu_pkg::PH_WAIT;
          pkt_o.num = 3'd1;
          pkt_o.kind = jsu_pkg::KIND_ERR;
        end
      end
      jsu_pkg::PH_LOW_HEX3: begin
        if (!hx[4] || cu_n[15:10] != 6'b110111) begin
          if (hx[4]) cu_d = cu_n;
          phase_d = jsu_pkg::PH_WAIT;
          pkt_o.num = 3'd1;
          pkt_o.kind = jsu_pkg::KIND_ERR;
        end else begin
          cu_d = cu_n;
          phase_d = jsu_pkg::PH_STR;
          pkt_o.num = 3'd4;
          pkt_o.bytes[0] = {5'b11110, cp[20:18]};
          pkt_o.bytes[1] = {2'b10, cp[17:12]};
          pkt_o.bytes[2] = {2'b10, cp[11:6]};
          pkt_o.bytes[3] = {2'b10, cp[5:0]};
        end
      end
      default: begin
        phase_d = jsu_pkg::PH_WAIT;
        pkt_o.num = 3'd1;
        pkt_o.kind = jsu_pkg::KIND_ERR;
      end
    endcase
    // saturating count of decoded data bytes
    if (pkt_o.kind == jsu_pkg::KIND_DATA) begin
      sum = {1'b0, cnt_q} + {{(jsu_pkg::LenW - 2){1'b0}}, pkt_o.num};
    end else begin
      sum = {1'b0, cnt_q};
    end
    cnt_d = sum[jsu_pkg::LenW] ? '1 : sum[jsu_pkg::LenW-1:0];
    if (phase_q == jsu_pkg::PH_WAIT && in_byte_i == ChQuote) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_WAIT;
      cu_q <= '0;
      hb_q <= '0;
      cnt_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      cu_q <= cu_d;
      hb_q <= hb_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/jsu_emit.sv
// Result register: holds one item's results and sends them out one per cycle while m_axis_tready is high.
module jsu_emit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  jsu_pkg::pkt_t            pkt_i,
  output logic                     ready_o,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [23:0]              m_axis_tdata,  // out_byte[7:0], decoded_length[23:8]
  output logic [1:0]               m_axis_tuser,  // kind[1:0]
  output logic                     m_axis_tlast
);

  `include "json_string_unescape_utf8_top_assert.svh"

  logic [2:0]                          num_q, num_d;
  logic [jsu_pkg::MaxRes-1:0][7:0]     bytes_q, bytes_d;
  jsu_pkg::kind_e                      kind_q, kind_d;
  logic [jsu_pkg::LenW-1:0]            len_q, len_d;
  logic                                pop;

  assign pop = m_axis_tvalid && m_axis_tready;
  assign ready_o = (num_q == 3'd0) || (num_q == 3'd1 && m_axis_tready);

  always_comb begin
    num_d = num_q;
    bytes_d = bytes_q;
    kind_d = kind_q;
    len_d = len_q;
    if (load_i) begin
      num_d = pkt_i.num;
      bytes_d = pkt_i.bytes;
      kind_d = pkt_i.kind;
      len_d = pkt_i.len;
    end else if (pop) begin
      num_d = num_q - 3'd1;
      bytes_d = {8'h00, bytes_q[jsu_pkg::MaxRes-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
    end else begin
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    kind_q <= kind_d;
    len_q <= len_d;
  end

  assign m_axis_tvalid = (num_q != 3'd0);
  assign m_axis_tlast = (num_q == 3'd1);
  assign m_axis_tdata = {len_q, bytes_q[0]};
  assign m_axis_tuser = kind_q;

  `JSU_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |=> !m_axis_tvalid, "result valid during reset")
  `JSU_ASSERT(a_ctrl_single, m_axis_tvalid && kind_q != jsu_pkg::KIND_DATA |-> m_axis_tlast, "done or error not last")
  `JSU_ASSERT(a_num_range, num_q <= 3'd4, "more than four results held")
  `JSU_ASSERT(a_load_free, load_i |-> (num_q == 3'd0 || pop), "results overwritten")

endmodule

### sim/json_string_unescape_utf8_checker.sv
// Checker for the JSON string unescaper: watches both streams, predicts results, compares.
module json_string_unescape_utf8_checker
  import jsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [23:0] m_data_i,
  input  logic [1:0]  m_user_i,
  input  logic        m_last_i,
  output int unsigned failures_o,
  output int unsigned pending_o,
  output int unsigned data_seen_o,
  output int unsigned done_seen_o,
  output int unsigned err_seen_o
);

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0]      ch;
    kind_e           kind;
    logic [LenW-1:0] len;
    logic            last;
  } result_t;

  result_t         decoded_q[$];
  phase_e          ph        = PH_WAIT;
  logic [15:0]     unit_acc  = '0;
  logic [9:0]      hi_bits   = '0;
  logic [LenW-1:0] out_count = '0;
  int unsigned     mismatches = 0;
  int unsigned     n_data = 0, n_done = 0, n_err = 0;

  assign failures_o  = mismatches + pending_o;
  assign data_seen_o = n_data;
  assign done_seen_o = n_done;
  assign err_seen_o  = n_err;

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
    else return 1'b0;
    return 1'b1;
  endfunction

  task automatic emit(input logic [7:0] b, input kind_e k, input logic [LenW-1:0] l);
    result_t r;
    r.ch   = b;
    r.kind = k;
    r.len  = l;
    r.last = 1'b0;
    decoded_q.push_back(r);
  endtask

  task automatic emit_data(input logic [7:0] b);
    if (out_count != '1) out_count++;
    emit(b, KIND_DATA, '0);
  endtask

  task automatic abort_string();
    ph = PH_WAIT;
    emit('0, KIND_ERR, '0);
  endtask

  task automatic emit_bmp(input logic [15:0] u);
    if (u < 16'h0080) begin
      emit_data(u[7:0]);
    end else if (u < 16'h0800) begin
      emit_data({3'b110, u[10:6]});
      emit_data({2'b10, u[5:0]});
    end else begin
      emit_data({4'b1110, u[15:12]});
      emit_data({2'b10, u[11:6]});
      emit_data({2'b10, u[5:0]});
    end
  endtask

  task automatic decode_json_byte(input logic [7:0] c);
    int unsigned first;
    logic [3:0]  nib;
    logic [20:0] cp;
    first = decoded_q.size();
    case (ph)
      PH_WAIT: begin
        if (c == QUOTE) begin
          ph        = PH_STR;
          out_count = '0;
          unit_acc  = '0;
        end else begin
          abort_string();
        end
      end
      PH_STR: begin
        if (c == 8'h00) abort_string();
        else if (c == QUOTE) begin
          ph = PH_WAIT;
          emit('0, KIND_DONE, out_count);
        end else if (c == BSLASH) ph = PH_ESC;
        else emit_data(c);
      end
      PH_ESC: begin
        case (c)
          QUOTE, BSLASH: begin ph = PH_STR; emit_data(c); end
          "b": begin ph = PH_STR; emit_data(8'h08); end
          "f": begin ph = PH_STR; emit_data(8'h0C); end
          "n": begin ph = PH_STR; emit_data(8'h0A); end
          "r": begin ph = PH_STR; emit_data(8'h0D); end
          "t": begin ph = PH_STR; emit_data(8'h09); end
          "u": begin ph = PH_HEX0; unit_acc = '0; end
          default: abort_string();
        endcase
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (!hex_nibble(c, nib)) begin
          abort_string();
        end else begin
          unit_acc = {unit_acc[11:0], nib};
          if (ph != PH_HEX3) begin
            ph = phase_e'(ph + 1);
          end else if (unit_acc >= 16'hD800 && unit_acc < 16'hDC00) begin
            hi_bits = unit_acc[9:0];
            ph      = PH_LOW_BS;
          end else begin
            ph = PH_STR;
            emit_bmp(unit_acc);
          end
        end
      end
      PH_LOW_BS: begin
        if (c == BSLASH) ph = PH_LOW_U;
        else abort_string();
      end
      PH_LOW_U: begin
        if (c == "u") begin
          ph       = PH_LOW_HEX0;
          unit_acc = '0;
        end else begin
          abort_string();
        end
      end
      PH_LOW_HEX0, PH_LOW_HEX1, PH_LOW_HEX2, PH_LOW_HEX3: begin
        if (!hex_nibble(c, nib)) begin
          abort_string();
        end else begin
          unit_acc = {unit_acc[11:0], nib};
          if (ph != PH_LOW_HEX3) begin
            ph = phase_e'(ph + 1);
          end else if (unit_acc < 16'hDC00 || unit_acc > 16'hDFFF) begin
            abort_string();
          end else begin
            cp = {1'b0, hi_bits, unit_acc[9:0]} + 21'h10000;
            ph = PH_STR;
            emit_data({5'b11110, cp[20:18]});
            emit_data({2'b10, cp[17:12]});
            emit_data({2'b10, cp[11:6]});
            emit_data({2'b10, cp[5:0]});
          end
        end
      end
      default: abort_string();
    endcase
    if (decoded_q.size() > first) decoded_q[$].last = 1'b1;
  endtask

  task automatic flag_result(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: expected byte %h kind %0d len %0d last %b,",
                " got byte %h kind %0d len %0d last %b"},
               $realtime, what, want.ch, want.kind, want.len, want.last,
               got.ch, got.kind, got.len, got.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      ph        = PH_WAIT;
      unit_acc  = '0;
      hi_bits   = '0;
      out_count = '0;
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      if (s_valid_i && s_ready_i) decode_json_byte(s_data_i);
      if (m_valid_i && m_ready_i) begin
        got.ch   = m_data_i[7:0];
        got.kind = kind_e'(m_user_i);
        got.len  = m_data_i[23:8];
        got.last = m_last_i;
        if (decoded_q.size() == 0) begin
          flag_result("unexpected item", '0, got);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) flag_result("item mismatch", want, got);
          case (want.kind)
            KIND_DATA: n_data++;
            KIND_DONE: n_done++;
            default:   n_err++;
          endcase
        end
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

### sim/tb.sv
// Testbench top: clock, reset, byte stimulus with random gaps and stalls, verdict.
module tb;
  import jsu_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned ITEM_GOAL  = 240;
  localparam logic [7:0]  QUOTE      = 8'h22;
  localparam logic [7:0]  BSLASH     = 8'h5C;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned failures, pending, data_seen, done_seen, err_seen;
  int unsigned sent        = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_odds    = 0;
  int unsigned stall_odds  = 0;
  bit          calm        = 1'b0;

  always #1 clk_i = ~clk_i;

  json_string_unescape_utf8_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  json_string_unescape_utf8_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .m_last_i    (m_axis_tlast),
    .failures_o  (failures),
    .pending_o   (pending),
    .data_seen_o (data_seen),
    .done_seen_o (done_seen),
    .err_seen_o  (err_seen)
  );

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 12;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit up);
    if (n < 10) return 8'h30 + n;
    return (up ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [15:0] random_bmp();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
      3:       return 16'($urandom_range(16'hDC00, 16'hDFFF));
      default: return 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == QUOTE || b == BSLASH);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_unit(input logic [15:0] u);
    bit up;
    up = 1'($urandom_range(0, 1));
    send_byte(BSLASH);
    send_byte("u");
    for (int i = 3; i >= 0; i--) send_byte(hex_char(u[4*i +: 4], up));
  endtask

  task automatic send_bad_hex();
    logic [7:0] b;
    send_byte(BSLASH);
    send_byte("u");
    repeat ($urandom_range(0, 3))
      send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    do b = 8'($urandom_range(0, 255)); while (is_hex(b));
    send_byte(b);
  endtask

  task automatic send_high_unit();
    send_unit(16'hD800 | 16'($urandom_range(0, 1023)));
  endtask

  task automatic send_token();
    case ($urandom_range(0, 4))
      0, 1: send_byte(plain_byte());
      2: begin
        send_byte(BSLASH);
        case ($urandom_range(0, 6))
          0:       send_byte(QUOTE);
          1:       send_byte(BSLASH);
          2:       send_byte("b");
          3:       send_byte("f");
          4:       send_byte("n");
          5:       send_byte("r");
          default: send_byte("t");
        endcase
      end
      3: send_unit(random_bmp());
      default: begin
        send_high_unit();
        send_unit(16'hDC00 | 16'($urandom_range(0, 1023)));
      end
    endcase
  endtask

  // ends the string in one of the error paths
  task automatic send_broken();
    logic [7:0]  b;
    logic [15:0] u;
    case ($urandom_range(0, 5))
      0: send_byte(8'h00);
      1: begin
        send_byte(BSLASH);
        if ($urandom_range(0, 1)) b = "/";
        else do b = 8'($urandom_range(0, 255));
          while (b inside {QUOTE, BSLASH, "b", "f", "n", "r", "t", "u"});
        send_byte(b);
      end
      2: send_bad_hex();
      3: begin
        send_high_unit();
        do b = 8'($urandom_range(0, 255)); while (b == BSLASH);
        send_byte(b);
      end
      4: begin
        send_high_unit();
        send_byte(BSLASH);
        do b = 8'($urandom_range(0, 255)); while (b == "u");
        send_byte(b);
      end
      default: begin
        send_high_unit();
        if ($urandom_range(0, 1)) begin
          send_bad_hex();
        end else begin
          do u = 16'($urandom_range(0, 16'hFFFF)); while (u >= 16'hDC00 && u <= 16'hDFFF);
          send_unit(u);
        end
      end
    endcase
  endtask

  task automatic send_string();
    logic [7:0] b;
    gap_odds = pick_odds();
    send_byte(QUOTE);
    repeat ($urandom_range(0, 8)) send_token();
    if ($urandom_range(0, 9) < 7) send_byte(QUOTE);
    else send_broken();
    // stray bytes outside a string
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        do b = 8'($urandom_range(0, 255)); while (b == QUOTE);
        send_byte(b);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 63) == 0) stall_odds = pick_odds();
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stray byte, extremes of plain bytes, lone low surrogate,
    // surrogate pair with the largest high half, NUL inside a string
    send_byte("A");
    send_byte(QUOTE);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_unit(16'hDFFF);
    send_unit(16'hDBFF);
    send_unit(16'hDC00);
    send_byte(QUOTE);
    send_byte(QUOTE);
    send_byte(8'h00);

    while (sent < ITEM_GOAL / 2) send_string();
    drain();
    while (sent < ITEM_GOAL) send_string();

    // no idling from here on
    calm = 1'b1;
    send_byte(QUOTE);
    send_high_unit();
    send_unit(16'hDC00 | 16'($urandom_range(0, 1023)));
    send_byte(QUOTE);
    repeat (4) send_string();

    drain();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d input bytes; got %0d decoded bytes, %0d finished strings, %0d errors.",
             sent, data_seen, done_seen, err_seen);
    $display("Included escapes, surrogate pairs, broken escapes and stray bytes.");
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
